>>> design/dual_heater_time_proportional_macros.svh
// ----------------------------------------------------------------------------
// Dual heater controller assertion macros
// Shared concurrent assertion forms for the dual heater relay controller.
// ----------------------------------------------------------------------------
`ifndef DUAL_HEATER_TIME_PROPORTIONAL_MACROS_SVH
`define DUAL_HEATER_TIME_PROPORTIONAL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dual heater check failed");

// The consequent must hold in the cycle after the antecedent.
`define DHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dual heater check failed");

`endif

>>> design/dht_pkg.sv
// ----------------------------------------------------------------------------
// Dual heater controller package
// Register indexes, fixed field widths, reset values and shared types.
// ----------------------------------------------------------------------------
package dht_pkg;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Fixed register widths.
    localparam int SEL_W    = 2;
    localparam int TARGET_W = 12;
    localparam int HYST_W   = 8;
    localparam int GAIN_W   = 16;
    localparam int CYCLE_W  = 10;

    // Result field widths and packing.
    localparam int DUTY_OUT_W  = 10;
    localparam int PHASE_OUT_W = 10;
    localparam int OUT_USED_W  = 4 + 2 * DUTY_OUT_W + PHASE_OUT_W;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Duty arithmetic: gain is Q8.8 per degree, distance is quarter degrees.
    localparam int DUTY_SHIFT  = 10;
    localparam int DUTY_MARGIN = 5;

    // Reset values of the registers that do not reset to zero.
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd256;
    localparam int                CYCLE_RESET = 100;

    // Queue between the front and back halves.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HEAT_ENABLE   = 3'd0,
        CFG_SENSOR_SELECT = 3'd1,
        CFG_TARGET_TEMP   = 3'd2,
        CFG_HYSTERESIS    = 3'd3,
        CFG_GAIN_ONE      = 3'd4,
        CFG_GAIN_TWO      = 3'd5,
        CFG_CYCLE_LENGTH  = 3'd6
    } t_cfg_reg;

    // Per-tick classification handed from the front to the back.
    typedef struct packed {
        logic enable;
        logic heat_two;
        logic heat_one;
    } t_chan_flags;

endpackage

>>> design/dht_front.sv
// ----------------------------------------------------------------------------
// Dual heater front end
// Picks each channel's sensor, decides heating and forms the distance to target.
// ----------------------------------------------------------------------------
module dht_front #(
    parameter int TEMP_BITS = 12
) (
    input  logic [TEMP_BITS-1:0]         i_temp_external,
    input  logic [TEMP_BITS-1:0]         i_temp_inner_one,
    input  logic [TEMP_BITS-1:0]         i_temp_inner_two,
    input  logic                         i_heat_enable,
    input  logic [dht_pkg::SEL_W-1:0]    i_sensor_select,
    input  logic [TEMP_BITS-1:0]         i_target,
    input  logic [dht_pkg::HYST_W-1:0]   i_hysteresis,
    output dht_pkg::t_chan_flags         o_flags,
    output logic [TEMP_BITS-1:0]         o_dist_one,
    output logic [TEMP_BITS-1:0]         o_dist_two
);
    import dht_pkg::*;

    localparam int SUM_W = TEMP_BITS + 1;

    logic [TEMP_BITS-1:0] temp_one;
    logic [TEMP_BITS-1:0] temp_two;
    logic [SUM_W-1:0]     upper;

    // Absolute distance between a reading and the target.
    function automatic logic [TEMP_BITS-1:0] abs_diff(
        input logic [TEMP_BITS-1:0] a,
        input logic [TEMP_BITS-1:0] b
    );
        logic [TEMP_BITS-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    // Sensor selection: external sensor feeds both channels when select is zero.
    always_comb begin
        if (i_sensor_select == '0) begin
            temp_one = i_temp_external;
            temp_two = i_temp_external;
        end else begin
            temp_one = i_temp_inner_one;
            temp_two = i_temp_inner_two;
        end
    end

    // A channel heats below target plus hysteresis, and only while enabled.
    always_comb begin
        upper            = SUM_W'(i_target) + SUM_W'(i_hysteresis);
        o_flags.enable   = i_heat_enable;
        o_flags.heat_one = i_heat_enable && (SUM_W'(temp_one) < upper);
        o_flags.heat_two = i_heat_enable && (SUM_W'(temp_two) < upper);
        o_dist_one       = abs_diff(temp_one, i_target);
        o_dist_two       = abs_diff(temp_two, i_target);
    end

endmodule

>>> design/dht_queue.sv
// ----------------------------------------------------------------------------
// Dual heater item queue
// Short first-in first-out buffer between the front and back halves.
// ----------------------------------------------------------------------------
module dht_queue #(
    parameter int WIDTH = 27
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import dht_pkg::*;

    logic [WIDTH-1:0]       r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   do_push;
    logic                   do_pop;

    // Pointer advance with wrap at the queue depth.
    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        logic [QUEUE_PTR_W-1:0] q;
        q = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    // Status and next pointer values.
    always_comb begin
        o_ready  = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
        o_valid  = (r_count != '0);
        o_data   = r_mem[r_rd_ptr];
        do_push  = i_push && o_ready;
        do_pop   = i_pop && o_valid;
        n_wr_ptr = do_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> design/dht_back.sv
// ----------------------------------------------------------------------------
// Dual heater back end
// Multiplies gain by distance, saturates the duty, steps relays and phase.
// ----------------------------------------------------------------------------
module dht_back #(
    parameter int TEMP_BITS  = 12,
    parameter int PHASE_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  dht_pkg::t_chan_flags             i_q_flags,
    input  logic [TEMP_BITS-1:0]             i_q_dist_one,
    input  logic [TEMP_BITS-1:0]             i_q_dist_two,
    output logic                             o_q_pop,
    input  logic [dht_pkg::GAIN_W-1:0]       i_gain_one,
    input  logic [dht_pkg::GAIN_W-1:0]       i_gain_two,
    input  logic [PHASE_BITS-1:0]            i_cycle_len,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [dht_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import dht_pkg::*;

    localparam int PROD_W = GAIN_W + TEMP_BITS;
    localparam int SH_W   = PROD_W - DUTY_SHIFT;
    localparam int CMP_W  = (SH_W > PHASE_BITS) ? SH_W : PHASE_BITS;
    localparam int INC_W  = PHASE_BITS + 1;
    localparam int PAD_W  = OUT_DATA_W - OUT_USED_W;

    // Stage A: registered products.
    logic                  r_a_valid;
    t_chan_flags           r_a_flags;
    logic [PROD_W-1:0]     r_a_prod_one;
    logic [PROD_W-1:0]     r_a_prod_two;

    // Stage B: controller state and the result register.
    logic [PHASE_BITS-1:0] r_phase;
    logic                  r_relay_one;
    logic                  r_relay_two;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [PHASE_BITS-1:0] n_phase;
    logic                  n_relay_one;
    logic                  n_relay_two;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic                  advance;
    logic [PHASE_BITS-1:0] bound;
    logic [PHASE_BITS-1:0] duty_one;
    logic [PHASE_BITS-1:0] duty_two;
    logic [INC_W-1:0]      phase_inc;
    logic [PHASE_BITS-1:0] phase_wrap;

    // Duty from a product: shift to ticks, clamp to the bound, zero when idle.
    function automatic logic [PHASE_BITS-1:0] sat_duty(
        input logic [PROD_W-1:0]     prod,
        input logic                  heat,
        input logic [PHASE_BITS-1:0] lim
    );
        logic [CMP_W-1:0]      sh;
        logic [PHASE_BITS-1:0] d;
        sh = CMP_W'(prod[PROD_W-1:DUTY_SHIFT]);
        if (!heat) begin
            d = '0;
        end else if (sh > CMP_W'(lim)) begin
            d = lim;
        end else begin
            d = sh[PHASE_BITS-1:0];
        end
        return d;
    endfunction

    // Relay step: on at phase zero with a nonzero duty, off when phase meets duty or when not heating.
    function automatic logic relay_step(
        input logic                  cur,
        input logic                  heat,
        input logic [PHASE_BITS-1:0] phase,
        input logic [PHASE_BITS-1:0] duty
    );
        logic r;
        priority if (!heat) begin
            r = 1'b0;
        end else if (phase == '0) begin
            r = (duty != '0);
        end else if (phase == duty) begin
            r = 1'b0;
        end else begin
            r = cur;
        end
        return r;
    endfunction

    // The whole back pipeline moves when the result register can take a new item.
    assign advance    = !r_out_valid || i_m_tready;
    assign o_q_pop    = advance && i_q_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Saturation, relay and phase logic for the item in stage A.
    always_comb begin
        bound = (i_cycle_len > PHASE_BITS'(DUTY_MARGIN))
              ? i_cycle_len - PHASE_BITS'(DUTY_MARGIN) : '0;
        duty_one   = sat_duty(r_a_prod_one, r_a_flags.heat_one, bound);
        duty_two   = sat_duty(r_a_prod_two, r_a_flags.heat_two, bound);
        phase_inc  = INC_W'(r_phase) + INC_W'(1);
        phase_wrap = (phase_inc > INC_W'(i_cycle_len)) ? '0 : phase_inc[PHASE_BITS-1:0];

        if (r_a_flags.enable) begin
            n_relay_one = relay_step(r_relay_one, r_a_flags.heat_one, r_phase, duty_one);
            n_relay_two = relay_step(r_relay_two, r_a_flags.heat_two, r_phase, duty_two);
            n_phase     = phase_wrap;
        end else begin
            n_relay_one = 1'b0;
            n_relay_two = 1'b0;
            n_phase     = r_phase;
        end

        n_out_data = {PAD_W'(0),
                      PHASE_OUT_W'(r_phase),
                      DUTY_OUT_W'(duty_two),
                      DUTY_OUT_W'(duty_one),
                      r_a_flags.heat_two,
                      r_a_flags.heat_one,
                      n_relay_two,
                      n_relay_one};
    end

    // Stage A valid, state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_relay_one <= 1'b0;
            r_relay_two <= 1'b0;
        end else if (advance) begin
            r_a_valid   <= i_q_valid;
            r_out_valid <= r_a_valid;
            if (r_a_valid) begin
                r_phase     <= n_phase;
                r_relay_one <= n_relay_one;
                r_relay_two <= n_relay_two;
            end
        end
    end

    // Payload registers: products and the packed result.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_flags    <= i_q_flags;
            r_a_prod_one <= PROD_W'(i_gain_one) * PROD_W'(i_q_dist_one);
            r_a_prod_two <= PROD_W'(i_gain_two) * PROD_W'(i_q_dist_two);
            r_out_data   <= n_out_data;
        end
    end

endmodule

>>> design/dual_heater_time_proportional.sv
// ----------------------------------------------------------------------------
// Dual heater time-proportional relay controller
// Two-channel slow-PWM heater control driven by one tick item per period.
// ----------------------------------------------------------------------------
//  Channel    Direction  Handshake                      Payload
//  s_axis     in         i_s_axis_tvalid/o_s_axis_tready  three readings
//  m_axis     out        o_m_axis_tvalid/i_m_axis_tready  relays, heat, duty, phase
//  cfg        in         i_cfg_we                         index and write data
//
// A result passes from the queue through the gain multipliers into the result
// register; the duty clamp with the relay and phase step happen as it enters
// the result register. A new item is taken every cycle while the queue is not
// full; the relay state updates once per item, and the phase steps only for
// items with heating enabled. Reset clears the queue, pipeline valids, phase
// counter and relays, and loads the register reset values. A stalled result
// holds the back pipeline while the two-entry queue keeps taking items until
// it fills.
// ----------------------------------------------------------------------------
`include "dual_heater_time_proportional_macros.svh"

module dual_heater_time_proportional #(
    parameter int TEMP_BITS  = 12,
    parameter int PHASE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input items.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // temp_external, temp_inner_one, temp_inner_two
    input  logic [((3*TEMP_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    // Result items.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // relay_one_on, relay_two_on, heating_one, heating_two, duty_one, duty_two,
    // phase_now
    output logic [dht_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // Configuration writes.
    input  logic                                i_cfg_we,
    input  logic [dht_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [dht_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import dht_pkg::*;

    localparam int QW    = $bits(t_chan_flags) + 2 * TEMP_BITS;
    localparam int CHK_W = ((PHASE_BITS > DUTY_OUT_W) ? PHASE_BITS : DUTY_OUT_W) + 1;

    // Configuration registers.
    logic                  r_heat_enable;
    logic [SEL_W-1:0]      r_sensor_select;
    logic [TEMP_BITS-1:0]  r_target;
    logic [HYST_W-1:0]     r_hysteresis;
    logic [GAIN_W-1:0]     r_gain_one;
    logic [GAIN_W-1:0]     r_gain_two;
    logic [PHASE_BITS-1:0] r_cycle_len;

    // Front to queue.
    t_chan_flags           front_flags;
    logic [TEMP_BITS-1:0]  front_dist_one;
    logic [TEMP_BITS-1:0]  front_dist_two;
    logic [QW-1:0]         q_in_data;

    // Queue to back.
    logic                  q_valid;
    logic                  q_pop;
    logic [QW-1:0]         q_out_data;
    t_chan_flags           q_flags;
    logic [TEMP_BITS-1:0]  q_dist_one;
    logic [TEMP_BITS-1:0]  q_dist_two;

    // Result fields for checking.
    logic                  out_relay_one;
    logic                  out_relay_two;
    logic                  out_heat_one;
    logic                  out_heat_two;
    logic [DUTY_OUT_W-1:0] out_duty_one;
    logic [DUTY_OUT_W-1:0] out_duty_two;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_enable   <= 1'b0;
            r_sensor_select <= '0;
            r_target        <= '0;
            r_hysteresis    <= '0;
            r_gain_one      <= GAIN_RESET;
            r_gain_two      <= GAIN_RESET;
            r_cycle_len     <= PHASE_BITS'(CYCLE_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_HEAT_ENABLE:   r_heat_enable   <= i_cfg_wdata[0];
                CFG_SENSOR_SELECT: r_sensor_select <= i_cfg_wdata[SEL_W-1:0];
                CFG_TARGET_TEMP:   r_target        <= TEMP_BITS'(i_cfg_wdata[TARGET_W-1:0]);
                CFG_HYSTERESIS:    r_hysteresis    <= i_cfg_wdata[HYST_W-1:0];
                CFG_GAIN_ONE:      r_gain_one      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_TWO:      r_gain_two      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_CYCLE_LENGTH:  r_cycle_len     <= PHASE_BITS'(i_cfg_wdata[CYCLE_W-1:0]);
                default: ;
            endcase
        end
    end

    // Classification of the incoming item.
    dht_front #(
        .TEMP_BITS(TEMP_BITS)
    ) u_front (
        .i_temp_external (i_s_axis_tdata[TEMP_BITS-1:0]),
        .i_temp_inner_one(i_s_axis_tdata[2*TEMP_BITS-1:TEMP_BITS]),
        .i_temp_inner_two(i_s_axis_tdata[3*TEMP_BITS-1:2*TEMP_BITS]),
        .i_heat_enable   (r_heat_enable),
        .i_sensor_select (r_sensor_select),
        .i_target        (r_target),
        .i_hysteresis    (r_hysteresis),
        .o_flags         (front_flags),
        .o_dist_one      (front_dist_one),
        .o_dist_two      (front_dist_two)
    );

    assign q_in_data = {front_dist_two, front_dist_one, front_flags};

    // Queue between the halves.
    dht_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_s_axis_tvalid),
        .i_data (q_in_data),
        .o_ready(o_s_axis_tready),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_out_data)
    );

    assign q_flags    = t_chan_flags'(q_out_data[$bits(t_chan_flags)-1:0]);
    assign q_dist_one = q_out_data[$bits(t_chan_flags)+TEMP_BITS-1:$bits(t_chan_flags)];
    assign q_dist_two = q_out_data[QW-1:$bits(t_chan_flags)+TEMP_BITS];

    // Duty, relay and phase processing.
    dht_back #(
        .TEMP_BITS (TEMP_BITS),
        .PHASE_BITS(PHASE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_flags   (q_flags),
        .i_q_dist_one(q_dist_one),
        .i_q_dist_two(q_dist_two),
        .o_q_pop     (q_pop),
        .i_gain_one  (r_gain_one),
        .i_gain_two  (r_gain_two),
        .i_cycle_len (r_cycle_len),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata)
    );

    // Result fields taken apart for the checks below.
    assign out_relay_one = o_m_axis_tdata[0];
    assign out_relay_two = o_m_axis_tdata[1];
    assign out_heat_one  = o_m_axis_tdata[2];
    assign out_heat_two  = o_m_axis_tdata[3];
    assign out_duty_one  = o_m_axis_tdata[4+DUTY_OUT_W-1:4];
    assign out_duty_two  = o_m_axis_tdata[4+2*DUTY_OUT_W-1:4+DUTY_OUT_W];

    // A relay is only ever on for a channel that is heating.
    `DHT_ASSERT_IMPLIES(a_relay_one_heat, i_clk, i_rst_n, o_m_axis_tvalid && out_relay_one, out_heat_one)
    `DHT_ASSERT_IMPLIES(a_relay_two_heat, i_clk, i_rst_n, o_m_axis_tvalid && out_relay_two, out_heat_two)

    // A nonzero duty leaves the margin below the cycle length.
    `DHT_ASSERT_IMPLIES(a_duty_one_bound, i_clk, i_rst_n, o_m_axis_tvalid && (out_duty_one != '0), CHK_W'(out_duty_one) + CHK_W'(DUTY_MARGIN) <= CHK_W'(r_cycle_len))
    `DHT_ASSERT_IMPLIES(a_duty_two_bound, i_clk, i_rst_n, o_m_axis_tvalid && (out_duty_two != '0), CHK_W'(out_duty_two) + CHK_W'(DUTY_MARGIN) <= CHK_W'(r_cycle_len))

endmodule
